// ----- rtl/keypoint_radius_nms_filter_defines.svh -----
// Assertion macros shared by the keypoint radius suppression filter.
`ifndef KEYPOINT_RADIUS_NMS_FILTER_DEFINES_SVH
`define KEYPOINT_RADIUS_NMS_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KRNF_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KRNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/krnf_pkg.sv -----
// Types, constants and helper functions of the keypoint radius suppression filter.
package krnf_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned STR_W      = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned RADIUS_W   = 8;
  localparam int unsigned RSQ_W      = 2 * RADIUS_W;
  // Q12.4 scaling of the radius squared: (r * 16)^2 = r^2 << 8.
  localparam int unsigned LIMIT_SHIFT = 8;
  // Distances are saturated to 12 bits: anything beyond is outside every radius.
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned SQ_W       = 2 * DIST_W;
  localparam int unsigned SUM_W      = SQ_W + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd10;
  localparam logic [RSQ_W-1:0]    LIMIT_RESET  = RSQ_W'(10 * 10);

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CMP,
    ST_POP,
    ST_DONE
  } krnf_state_e;

  // One stored keypoint.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STR_W-1:0]   s;
    logic [IDX_W-1:0]   idx;
  } point_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic load;   // sorted insertion of the new point
    logic cmp;    // square the distances to the head point
    logic shift;  // pop the head, shift the chain towards the head
    logic kill;   // the popped head survives and suppresses its neighbourhood
  } cell_cmd_t;

  // Absolute difference, saturated to DIST_W bits.
  function automatic logic [DIST_W-1:0] sat_dist(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return (d[COORD_W-1:DIST_W] != '0) ? '1 : d[DIST_W-1:0];
  endfunction

endpackage

// ----- rtl/krnf_cell.sv -----
// One cell of the sorted keypoint chain: storage, insertion compare and radius test.
module krnf_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  krnf_pkg::cell_cmd_t       cmd_i,
  input  krnf_pkg::point_t          new_i,
  input  logic [krnf_pkg::SQ_W-1:0] limit_i,
  input  logic [krnf_pkg::COORD_W-1:0] head_x_i,
  input  logic [krnf_pkg::COORD_W-1:0] head_y_i,
  // Left neighbour (towards the head).
  input  krnf_pkg::point_t          left_data_i,
  input  logic                      left_valid_i,
  input  logic                      left_ge_i,
  // Right neighbour (towards the tail).
  input  krnf_pkg::point_t          right_data_i,
  input  logic                      right_valid_i,
  input  logic                      right_keep_i,
  output krnf_pkg::point_t          data_o,
  output logic                      valid_o,
  output logic                      alive_o,
  output logic                      ge_o,
  output logic                      keep_o
);
  import krnf_pkg::*;

  point_t            data_q, data_d;
  logic              valid_q, valid_d;
  logic              alive_q, alive_d;
  logic [SQ_W-1:0]   dx2_q, dx2_d;
  logic [SQ_W-1:0]   dy2_q, dy2_d;
  logic [DIST_W-1:0] dx, dy;
  logic              in_radius;

  // The new point belongs at or before this cell when it is strictly stronger.
  assign ge_o = !valid_q || (new_i.s > data_q.s);

  // Radius test on the squares registered in the compare cycle.
  assign in_radius = (SUM_W'(dx2_q) + SUM_W'(dy2_q)) <= SUM_W'(limit_i);
  assign keep_o    = alive_q && !(cmd_i.kill && in_radius);

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign alive_o = alive_q;

  // Distance squares against the head point.
  always_comb begin
    dx    = sat_dist(data_q.x, head_x_i);
    dy    = sat_dist(data_q.y, head_y_i);
    dx2_d = dx2_q;
    dy2_d = dy2_q;
    if (cmd_i.cmp) begin
      dx2_d = SQ_W'(dx) * SQ_W'(dx);
      dy2_d = SQ_W'(dy) * SQ_W'(dy);
    end
  end

  // Insertion shifts towards the tail, popping shifts towards the head.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    alive_d = alive_q;
    if (cmd_i.load && ge_o) begin
      if (left_ge_i) begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
        alive_d = left_valid_i;
      end else begin
        data_d  = new_i;
        valid_d = 1'b1;
        alive_d = 1'b1;
      end
    end else if (cmd_i.shift) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
      alive_d = right_keep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      alive_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    dx2_q  <= dx2_d;
    dy2_q  <= dy2_d;
  end

endmodule

// ----- rtl/krnf_ctrl.sv -----
// Controller: load counting, selection sequencing, result formation and radius register.
module krnf_ctrl #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          masked_i,
  input  logic                          final_point_i,
  input  logic                          suppress_radius_we_i,
  input  logic [krnf_pkg::RADIUS_W-1:0] suppress_radius_i,
  input  logic                          head_alive_i,
  input  logic [krnf_pkg::IDX_W-1:0]    head_idx_i,
  output krnf_pkg::cell_cmd_t           cmd_o,
  output logic [krnf_pkg::IDX_W-1:0]    new_idx_o,
  output logic [krnf_pkg::SQ_W-1:0]     limit_o,
  output logic                          result_valid_o,
  output logic [krnf_pkg::IDX_W-1:0]    point_index_o,
  output logic                          none_kept_o,
  output logic                          end_of_list_o
);
  import krnf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  krnf_state_e      state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             pend_vld_q, pend_vld_d;
  logic [RSQ_W-1:0] limit_q, limit_d;
  logic             res_vld_q, res_vld_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic             res_none_q, res_none_d;
  logic             res_last_q, res_last_d;
  logic             accept;
  logic             room;

  assign accept    = start && (state_q == ST_LOAD);
  assign room      = load_cnt_q < CNT_W'(MAX_POINTS);
  assign new_idx_o = IDX_W'(load_cnt_q);
  assign limit_o   = {limit_q, LIMIT_SHIFT'(0)};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (accept && final_point_i) state_d = ST_CMP;
      ST_CMP:  state_d = (fill_q == '0) ? ST_DONE : ST_POP;
      ST_POP:  state_d = ST_CMP;
      ST_DONE: state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // Handshake and cell commands.
  always_comb begin
    busy  = 1'b1;
    cmd_o = '0;
    case (state_q)
      ST_LOAD: begin
        busy       = 1'b0;
        cmd_o.load = start && room && !masked_i;
      end
      ST_CMP:  cmd_o.cmp = (fill_q != '0);
      ST_POP: begin
        cmd_o.shift = 1'b1;
        cmd_o.kill  = head_alive_i;
      end
      ST_DONE: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Counters, pending survivor and result formation.
  always_comb begin
    load_cnt_d = load_cnt_q;
    fill_d     = fill_q;
    pend_idx_d = pend_idx_q;
    pend_vld_d = pend_vld_q;
    res_vld_d  = 1'b0;
    res_idx_d  = res_idx_q;
    res_none_d = res_none_q;
    res_last_d = res_last_q;
    limit_d    = limit_q;

    if (accept && room) load_cnt_d = load_cnt_q + 1'b1;
    if (cmd_o.load) fill_d = fill_q + 1'b1;
    if (cmd_o.shift) fill_d = fill_q - 1'b1;

    // A survivor is held back one step so the last one can carry the end mark.
    if (state_q == ST_POP && head_alive_i) begin
      pend_idx_d = head_idx_i;
      pend_vld_d = 1'b1;
      if (pend_vld_q) begin
        res_vld_d  = 1'b1;
        res_idx_d  = pend_idx_q;
        res_none_d = 1'b0;
        res_last_d = 1'b0;
      end
    end

    if (state_q == ST_DONE) begin
      load_cnt_d = '0;
      pend_vld_d = 1'b0;
      res_vld_d  = 1'b1;
      res_idx_d  = pend_vld_q ? pend_idx_q : '0;
      res_none_d = !pend_vld_q;
      res_last_d = 1'b1;
    end

    if (suppress_radius_we_i) begin
      limit_d = RSQ_W'(suppress_radius_i) * RSQ_W'(suppress_radius_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      fill_q     <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      limit_q    <= LIMIT_RESET;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      fill_q     <= fill_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
      limit_q    <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    res_idx_q  <= res_idx_d;
    res_none_q <= res_none_d;
    res_last_q <= res_last_d;
  end

  assign result_valid_o = res_vld_q;
  assign point_index_o  = res_idx_q;
  assign none_kept_o    = res_none_q;
  assign end_of_list_o  = res_last_q;

endmodule

// ----- rtl/keypoint_radius_nms_filter.sv -----
// Top level of the keypoint radius non-maximum suppression filter.
// Keypoints are taken one per cycle while busy is low; each unmasked point is
// inserted into a chain of MAX_POINTS cells kept sorted by strength, strongest
// at the head, equal strengths in load order. The transfer that carries
// final_point raises busy. Selection then pops the head of the chain in two
// alternating steps: a compare state, in which every cell squares its distance
// to the head, and a pop state, in which the chain shifts and a surviving head
// clears every cell inside the radius, until every stored point is popped;
// busy drops as the last result appears. Results are single-cycle strobes on
// result_valid_o that the receiver must take as they come; a set with no
// survivor gives one result with none_kept_o set. The user must write
// suppress_radius only while busy is low; the block does not enforce this.
`include "keypoint_radius_nms_filter_defines.svh"

module keypoint_radius_nms_filter #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [krnf_pkg::COORD_W-1:0]  pos_x_i,
  input  logic [krnf_pkg::COORD_W-1:0]  pos_y_i,
  input  logic [krnf_pkg::STR_W-1:0]    strength_i,
  input  logic                          masked_i,
  input  logic                          final_point_i,
  input  logic                          suppress_radius_we_i,
  input  logic [krnf_pkg::RADIUS_W-1:0] suppress_radius_i,
  output logic                          result_valid_o,
  output logic [krnf_pkg::IDX_W-1:0]    point_index_o,
  output logic                          none_kept_o,
  output logic                          end_of_list_o
);
  import krnf_pkg::*;

  cell_cmd_t              cell_cmd;
  point_t                 new_point;
  logic [IDX_W-1:0]       new_idx;
  logic [SQ_W-1:0]        limit;
  point_t                 cell_data [MAX_POINTS];
  logic [MAX_POINTS-1:0]  cell_valid;
  logic [MAX_POINTS-1:0]  cell_alive;
  logic [MAX_POINTS-1:0]  cell_ge;
  logic [MAX_POINTS-1:0]  cell_keep;

  assign new_point = '{x: pos_x_i, y: pos_y_i, s: strength_i, idx: new_idx};

  // Sequencing and result formation.
  krnf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .masked_i,
    .final_point_i,
    .suppress_radius_we_i,
    .suppress_radius_i,
    .head_alive_i   (cell_alive[0]),
    .head_idx_i     (cell_data[0].idx),
    .cmd_o          (cell_cmd),
    .new_idx_o      (new_idx),
    .limit_o        (limit),
    .result_valid_o,
    .point_index_o,
    .none_kept_o,
    .end_of_list_o
  );

  // The sorted chain; cell 0 is the head.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    point_t left_data, right_data;
    logic   left_valid, left_ge, right_valid, right_keep;

    if (i == 0) begin : g_head
      assign left_data  = '0;
      assign left_valid = 1'b0;
      assign left_ge    = 1'b0;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
      assign right_keep  = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
      assign right_keep  = cell_keep[i+1];
    end

    krnf_cell u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i         (cell_cmd),
      .new_i         (new_point),
      .limit_i       (limit),
      .head_x_i      (cell_data[0].x),
      .head_y_i      (cell_data[0].y),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .left_ge_i     (left_ge),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .right_keep_i  (right_keep),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .alive_o       (cell_alive[i]),
      .ge_o          (cell_ge[i]),
      .keep_o        (cell_keep[i])
    );
  end

  // Checks on sequencing and result marking.
  `KRNF_ASSERT_HOLD(a_mid_result_busy, result_valid_o && !end_of_list_o, busy, "non-final result while idle")
  `KRNF_ASSERT_HOLD(a_empty_is_last, result_valid_o && none_kept_o, end_of_list_o, "empty result without end mark")
  `KRNF_ASSERT_HOLD(a_cmd_exclusive, 1'b1, $onehot0({cell_cmd.load, cell_cmd.cmp, cell_cmd.shift}), "overlapping cell commands")
  `KRNF_ASSERT_NEXT(a_final_goes_busy, start && !busy && final_point_i, busy, "final point transfer did not start selection")

endmodule
